>>> rtl/sdcm_pkg.sv
// Shared types and constants for the solenoid duty-cycle monitor.
// No dependencies; imported by every other file of the block.
package sdcm_pkg;

    localparam int DATA_W     = 32;
    localparam int MD_W       = 17;
    localparam int PLAN_W     = 16;
    localparam int PROD_W     = MD_W + DATA_W;
    localparam int MUL_STEPS  = 32;
    localparam int MUL_CNT_W  = 6;
    localparam int CFG_ADDR_W = 3;

    localparam logic [DATA_W-1:0] WINDOW_MS_RESET = 32'd10000;
    localparam logic [MD_W-1:0]   MAX_DUTY_RESET  = 17'h10000;

    localparam logic [0:0] REG_WINDOW_MS = 1'b0;
    localparam logic [0:0] REG_MAX_DUTY  = 1'b1;

    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CHECK = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef struct packed {
        logic [DATA_W-1:0] window_ms;
        logic [MD_W-1:0]   max_duty;
    } t_cfg;

endpackage

>>> rtl/sdcm_in_if.sv
// Input channel of the duty-cycle monitor: valid/ready plus one event item.
// Depends on sdcm_pkg.
interface sdcm_in_if import sdcm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [DATA_W-1:0] now_ms;
    logic              drive_on;
    logic [PLAN_W-1:0] planned_on_ms;

    modport source (output valid, action, now_ms, drive_on, planned_on_ms, input ready);
    modport sink   (input valid, action, now_ms, drive_on, planned_on_ms, output ready);
endinterface

>>> rtl/sdcm_out_if.sv
// Result channel of the duty-cycle monitor: valid/ready plus one status item.
// Depends on sdcm_pkg.
interface sdcm_out_if import sdcm_pkg::*;;
    logic              valid;
    logic              ready;
    logic              level_on;
    logic [DATA_W-1:0] on_duration_ms;
    logic [DATA_W-1:0] since_off_ms;
    logic [DATA_W-1:0] total_on_ms;
    logic [DATA_W-1:0] activation_total;
    logic [MD_W-1:0]   duty_fraction;
    logic              would_exceed;

    modport source (output valid, level_on, on_duration_ms, since_off_ms, total_on_ms,
                    activation_total, duty_fraction, would_exceed, input ready);
    modport sink   (input valid, level_on, on_duration_ms, since_off_ms, total_on_ms,
                    activation_total, duty_fraction, would_exceed, output ready);
endinterface

>>> rtl/sdcm_cfg.sv
// APB-style register file: window length and duty limit.
// Depends on sdcm_pkg.
module sdcm_cfg import sdcm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms <= WINDOW_MS_RESET;
            r_cfg.max_duty  <= MAX_DUTY_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2:2])
                REG_WINDOW_MS: r_cfg.window_ms <= pwdata;
                REG_MAX_DUTY:  r_cfg.max_duty  <= pwdata[MD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2:2])
            REG_WINDOW_MS: prdata = r_cfg.window_ms;
            REG_MAX_DUTY:  prdata = {{(DATA_W-MD_W){1'b0}}, r_cfg.max_duty};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

>>> rtl/sdcm_div.sv
// Restoring fraction divider, one quotient bit per cycle.
// Numerator must be below the denominator. Depends on sdcm_pkg.
module sdcm_div import sdcm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DATA_W-1:0]    i_num,
    input  logic [DATA_W-1:0]    i_den,
    output logic                 o_done,
    output logic [FRAC_BITS-1:0] o_quot
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_den;
    logic [FRAC_BITS-1:0] r_quot;
    logic [DATA_W:0]      w_trial;
    logic [DATA_W:0]      w_diff;
    logic                 w_fit;

    assign w_trial = {r_rem, 1'b0};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= w_fit ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
                r_quot <= {r_quot[FRAC_BITS-2:0], w_fit};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/sdcm_mul.sv
// Serial shift-add multiplier, one multiplier bit per cycle, 17 x 32 bits.
// Depends on sdcm_pkg.
module sdcm_mul import sdcm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MD_W-1:0]   i_mcand,
    input  logic [DATA_W-1:0] i_mplier,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MD_W-1:0]      r_mcand;
    logic [PROD_W-1:0]    r_prod;
    logic [MD_W:0]        w_sum;

    assign w_sum = {1'b0, r_prod[PROD_W-1:DATA_W]}
                 + (r_prod[0] ? {1'b0, r_mcand} : {(MD_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= MUL_CNT_W'(MUL_STEPS);
                r_mcand <= i_mcand;
                r_prod  <= {{MD_W{1'b0}}, i_mplier};
            end else if (r_busy) begin
                r_prod <= {w_sum, r_prod[DATA_W-1:1]};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

>>> rtl/solenoid_duty_cycle_monitor_unit.sv
// Top level of the solenoid duty-cycle monitor: sequencer, channel state, output register.
// Depends on sdcm_pkg, sdcm_in_if, sdcm_out_if, sdcm_cfg, sdcm_div, sdcm_mul.
//
// One item is worked at a time. A set, clear, or a query or check that needs no
// arithmetic passes through S_CALC1, S_CALC2, S_CALC3 and S_DONE before the next
// input transfer; a duty query that divides also waits in S_DIV for the divider,
// which produces one quotient bit per cycle; a pulse check against a limit waits
// in S_MUL for the 32 steps of the serial multiplier. S_DONE holds while the
// previous result is not taken. A finished result sits in the output register,
// so the next input transfer can happen while it waits.
module solenoid_duty_cycle_monitor_unit import sdcm_pkg::*; #(
    parameter int DUTY_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sdcm_in_if.sink               i_in,
    sdcm_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << DUTY_FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_CALC1, S_CALC2, S_CALC3, S_DIV, S_MUL, S_DONE
    } t_state;

    t_cfg w_cfg;

    t_state            r_state;
    t_action           r_act;
    logic [DATA_W-1:0] r_now;
    logic              r_drive;
    logic [PLAN_W-1:0] r_planned;

    logic              r_on_flag;
    logic [DATA_W-1:0] r_on_start;
    logic [DATA_W-1:0] r_off_stamp;
    logic              r_off_seen;
    logic [DATA_W-1:0] r_accum_on;
    logic [DATA_W-1:0] r_edge_count;
    logic [DATA_W-1:0] r_window_begin;
    logic              r_window_valid;
    logic [DATA_W-1:0] r_window_accum;

    logic [DATA_W-1:0] r_d;
    logic [DATA_W-1:0] r_age;
    logic [DATA_W-1:0] r_since;
    logic [DATA_W-1:0] r_wdelta;
    logic [DATA_W-1:0] r_on_t;
    logic [DATA_W-1:0] r_on_dur;
    logic [DATA_W-1:0] r_since_out;
    logic [DATA_W-1:0] r_total;
    logic [DATA_W-1:0] r_proj_on;
    logic [DATA_W-1:0] r_el_cap;
    logic              r_duty_zero;
    logic [MD_W-1:0]   r_duty;
    logic              r_exceed;
    logic              r_div_start;
    logic              r_mul_start;

    logic              r_out_valid;
    logic              r_o_level;
    logic [DATA_W-1:0] r_o_on_dur;
    logic [DATA_W-1:0] r_o_since;
    logic [DATA_W-1:0] r_o_total;
    logic [DATA_W-1:0] r_o_act_tot;
    logic [MD_W-1:0]   r_o_duty;
    logic              r_o_exceed;

    logic [DATA_W-1:0]         w_d;
    logic [DATA_W-1:0]         w_age;
    logic [DATA_W-1:0]         w_el;
    logic [DATA_W-1:0]         w_el_cap;
    logic                      w_chk_off;
    logic                      w_div_done;
    logic [DUTY_FRAC_BITS-1:0] w_quot;
    logic [DATA_W-1:0]         w_quot32;
    logic                      w_mul_done;
    logic [PROD_W-1:0]         w_prod;

    sdcm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sdcm_div #(.FRAC_BITS(DUTY_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_on_t),
        .i_den   (r_age),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    sdcm_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_mcand  (w_cfg.max_duty),
        .i_mplier (r_el_cap),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    assign w_d       = r_now - r_on_start;
    assign w_age     = r_now - r_window_begin;
    assign w_el      = (r_window_valid ? r_age : '0) + {{(DATA_W-PLAN_W){1'b0}}, r_planned};
    assign w_el_cap  = (w_el > w_cfg.window_ms) ? w_cfg.window_ms : w_el;
    assign w_chk_off = (w_cfg.window_ms == '0)
                    || ({{(DATA_W-MD_W){1'b0}}, w_cfg.max_duty} >= ONE_Q);
    assign w_quot32  = DATA_W'(w_quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_on_flag      <= 1'b0;
            r_on_start     <= '0;
            r_off_stamp    <= '0;
            r_off_seen     <= 1'b0;
            r_accum_on     <= '0;
            r_edge_count   <= '0;
            r_window_begin <= '0;
            r_window_valid <= 1'b0;
            r_window_accum <= '0;
            r_div_start    <= 1'b0;
            r_mul_start    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_act     <= t_action'(i_in.action);
                        r_now     <= i_in.now_ms;
                        r_drive   <= i_in.drive_on;
                        r_planned <= i_in.planned_on_ms;
                        r_state   <= S_CALC1;
                    end
                end
                S_CALC1: begin
                    r_d      <= w_d;
                    r_age    <= w_age;
                    r_since  <= r_now - r_off_stamp;
                    r_wdelta <= (!r_window_valid || r_on_start >= r_window_begin) ? w_d : w_age;
                    r_duty   <= '0;
                    r_exceed <= 1'b0;
                    r_state  <= S_CALC2;
                end
                S_CALC2: begin
                    r_on_t      <= r_window_accum + (r_on_flag ? r_wdelta : '0);
                    r_duty_zero <= (w_cfg.window_ms == '0) || !r_window_valid
                                || (r_age >= w_cfg.window_ms) || (r_age == '0);
                    r_on_dur    <= r_on_flag ? r_d : '0;
                    r_since_out <= r_off_seen ? r_since : '1;
                    case (r_act)
                        ACT_SET: begin
                            if (r_drive && !r_on_flag) begin
                                r_on_start   <= r_now;
                                r_edge_count <= r_edge_count + 1'b1;
                                r_on_flag    <= 1'b1;
                                r_on_dur     <= '0;
                                if (!r_window_valid) begin
                                    r_window_begin <= r_now;
                                    r_window_valid <= 1'b1;
                                end
                            end else if (!r_drive && r_on_flag) begin
                                r_accum_on     <= r_accum_on + r_d;
                                r_window_accum <= r_window_accum + r_d;
                                r_off_stamp    <= r_now;
                                r_off_seen     <= 1'b1;
                                r_on_flag      <= 1'b0;
                                r_on_dur       <= '0;
                                r_since_out    <= '0;
                            end
                        end
                        ACT_QUERY: begin
                            if (w_cfg.window_ms != '0) begin
                                if (!r_window_valid) begin
                                    r_window_begin <= r_now;
                                    r_window_valid <= 1'b1;
                                    r_window_accum <= '0;
                                end else if (r_age >= w_cfg.window_ms) begin
                                    r_window_begin <= r_now;
                                    r_window_accum <= '0;
                                end
                            end
                        end
                        ACT_CHECK: ;
                        ACT_CLEAR: begin
                            r_accum_on     <= '0;
                            r_edge_count   <= '0;
                            r_window_begin <= '0;
                            r_window_valid <= 1'b0;
                            r_window_accum <= '0;
                        end
                        default: ;
                    endcase
                    r_state <= S_CALC3;
                end
                S_CALC3: begin
                    r_total   <= r_accum_on + r_on_dur;
                    r_proj_on <= r_on_t + {{(DATA_W-PLAN_W){1'b0}}, r_planned};
                    r_el_cap  <= w_el_cap;
                    r_state   <= S_DONE;
                    case (r_act)
                        ACT_QUERY: begin
                            if (r_duty_zero) begin
                                r_duty <= '0;
                            end else if (r_on_t >= r_age) begin
                                r_duty <= ONE_Q[MD_W-1:0];
                            end else begin
                                r_div_start <= 1'b1;
                                r_state     <= S_DIV;
                            end
                        end
                        ACT_CHECK: begin
                            if (!w_chk_off && (w_el_cap != '0)) begin
                                r_mul_start <= 1'b1;
                                r_state     <= S_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        r_duty  <= w_quot32[MD_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_MUL: begin
                    r_mul_start <= 1'b0;
                    if (w_mul_done) begin
                        r_exceed <= {{(PROD_W-DATA_W){1'b0}}, r_proj_on}
                                  > (w_prod >> DUTY_FRAC_BITS);
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_level   <= r_on_flag;
                        r_o_on_dur  <= r_on_dur;
                        r_o_since   <= r_since_out;
                        r_o_total   <= r_total;
                        r_o_act_tot <= r_edge_count;
                        r_o_duty    <= r_duty;
                        r_o_exceed  <= r_exceed;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.level_on         = r_o_level;
    assign o_out.on_duration_ms   = r_o_on_dur;
    assign o_out.since_off_ms     = r_o_since;
    assign o_out.total_on_ms      = r_o_total;
    assign o_out.activation_total = r_o_act_tot;
    assign o_out.duty_fraction    = r_o_duty;
    assign o_out.would_exceed     = r_o_exceed;

endmodule
